/* design/moau_pkg.sv */
// Shared types and constants for the 3D Morton octree address unit.
// No dependencies.
`default_nettype none

package moau_pkg;

    localparam int CODE_W         = 30;
    localparam int PORT_COORD_W   = 10;
    localparam int COORD_BITS_DEF = 10;
    localparam int MODE_W         = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENCODE    = 3'd0,
        MODE_DECODE    = 3'd1,
        MODE_PARENT    = 3'd2,
        MODE_CHILDREN  = 3'd3,
        MODE_NEIGHBORS = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        OFF_NEG  = 2'd0,
        OFF_ZERO = 2'd1,
        OFF_POS  = 2'd2
    } off_t;

    typedef struct packed {
        off_t dz;
        off_t dy;
        off_t dx;
    } nb_t;

    localparam nb_t NB_CENTER = '{dz: OFF_ZERO, dy: OFF_ZERO, dx: OFF_ZERO};

endpackage

`default_nettype wire

/* design/morton_octree_address_unit.sv */
// Morton octree address unit: encode, decode, parent, children and neighbors.
// Depends on moau_pkg.
//
//  channel | ports                                             | dir
//  --------+---------------------------------------------------+-----
//  s_      | s_valid s_ready s_mode s_morton_in s_coord_x/y/z  | in
//  m_      | m_valid m_ready m_out_code m_out_x/y/z m_last     | out
//
// One result word per cycle out of the work register while m_ready allows;
// encode, decode and parent give one word each, so a new word is taken every cycle.
// Children hold the work register for 8 words, neighbors for 7 to 26.
// Mode codes 5 to 7 are taken and dropped with no result.
// Reset clears both valid flags. A stalled output holds the result register.
`default_nettype none

module morton_octree_address_unit #(
    parameter int COORD_BITS = moau_pkg::COORD_BITS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [moau_pkg::MODE_W-1:0]      s_mode,
    input  wire  [moau_pkg::CODE_W-1:0]      s_morton_in,
    input  wire  [moau_pkg::PORT_COORD_W-1:0] s_coord_x,
    input  wire  [moau_pkg::PORT_COORD_W-1:0] s_coord_y,
    input  wire  [moau_pkg::PORT_COORD_W-1:0] s_coord_z,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [moau_pkg::CODE_W-1:0]      m_out_code,
    output logic [moau_pkg::PORT_COORD_W-1:0] m_out_x,
    output logic [moau_pkg::PORT_COORD_W-1:0] m_out_y,
    output logic [moau_pkg::PORT_COORD_W-1:0] m_out_z,
    output logic                             m_last
);

    typedef logic [COORD_BITS-1:0] crd_t;

    function automatic logic [moau_pkg::CODE_W-1:0] interleave(crd_t x, crd_t y, crd_t z);
        logic [moau_pkg::CODE_W-1:0] c;
        c = '0;
        for (int i = 0; i < COORD_BITS; i++) begin
            c[3*i]   = x[i];
            c[3*i+1] = y[i];
            c[3*i+2] = z[i];
        end
        return c;
    endfunction

    function automatic crd_t gather(logic [moau_pkg::CODE_W-1:0] c, int sel);
        crd_t r;
        r = '0;
        for (int i = 0; i < COORD_BITS; i++) begin
            r[i] = c[3*i+sel];
        end
        return r;
    endfunction

    function automatic moau_pkg::off_t lo_of(crd_t v);
        return (v == '0) ? moau_pkg::OFF_ZERO : moau_pkg::OFF_NEG;
    endfunction

    function automatic moau_pkg::off_t hi_of(crd_t v);
        return (&v) ? moau_pkg::OFF_ZERO : moau_pkg::OFF_POS;
    endfunction

    function automatic moau_pkg::nb_t nb_step(moau_pkg::nb_t t, moau_pkg::nb_t lo,
                                             moau_pkg::nb_t hi);
        moau_pkg::nb_t r;
        r = t;
        if (t.dx != hi.dx) begin
            r.dx = moau_pkg::off_t'(t.dx + 2'd1);
        end else begin
            r.dx = lo.dx;
            if (t.dy != hi.dy) begin
                r.dy = moau_pkg::off_t'(t.dy + 2'd1);
            end else begin
                r.dy = lo.dy;
                r.dz = moau_pkg::off_t'(t.dz + 2'd1);
            end
        end
        return r;
    endfunction

    function automatic crd_t add_off(crd_t v, moau_pkg::off_t d);
        crd_t r;
        case (d)
            moau_pkg::OFF_NEG: r = v - COORD_BITS'(1);
            moau_pkg::OFF_POS: r = v + COORD_BITS'(1);
            default:           r = v;
        endcase
        return r;
    endfunction

    // work register
    logic            a_valid_reg, a_valid_next;
    moau_pkg::mode_t a_mode_reg, a_mode_next;
    crd_t            a_x_reg, a_x_next;
    crd_t            a_y_reg, a_y_next;
    crd_t            a_z_reg, a_z_next;
    logic [2:0]      a_cnt_reg, a_cnt_next;
    moau_pkg::nb_t   a_nb_reg, a_nb_next;

    // result register
    logic                              m_valid_reg, m_valid_next;
    logic [moau_pkg::CODE_W-1:0]       m_code_reg, m_code_next;
    crd_t                              m_x_reg, m_x_next;
    crd_t                              m_y_reg, m_y_next;
    crd_t                              m_z_reg, m_z_next;
    logic                              m_last_reg, m_last_next;

    logic          in_mode_ok, a_load, out_free, a_fire, res_last;
    crd_t          in_x, in_y, in_z, res_x, res_y, res_z;
    moau_pkg::nb_t in_lo, in_hi, in_start, lo, hi, nxt1, nxt;

    assign out_free = !m_valid_reg || m_ready;
    assign a_fire   = a_valid_reg && out_free;
    assign s_ready  = !a_valid_reg || (a_fire && res_last);
    assign a_load   = s_valid && s_ready && in_mode_ok;

    always_comb begin
        in_mode_ok = s_mode inside {[moau_pkg::MODE_ENCODE : moau_pkg::MODE_NEIGHBORS]};
        if (moau_pkg::mode_t'(s_mode) == moau_pkg::MODE_ENCODE) begin
            in_x = s_coord_x[COORD_BITS-1:0];
            in_y = s_coord_y[COORD_BITS-1:0];
            in_z = s_coord_z[COORD_BITS-1:0];
        end else begin
            in_x = gather(s_morton_in, 0);
            in_y = gather(s_morton_in, 1);
            in_z = gather(s_morton_in, 2);
        end
        in_lo    = '{dz: lo_of(in_z), dy: lo_of(in_y), dx: lo_of(in_x)};
        in_hi    = '{dz: hi_of(in_z), dy: hi_of(in_y), dx: hi_of(in_x)};
        in_start = (in_lo == moau_pkg::NB_CENTER) ? nb_step(in_lo, in_lo, in_hi) : in_lo;
    end

    always_comb begin
        lo   = '{dz: lo_of(a_z_reg), dy: lo_of(a_y_reg), dx: lo_of(a_x_reg)};
        hi   = '{dz: hi_of(a_z_reg), dy: hi_of(a_y_reg), dx: hi_of(a_x_reg)};
        nxt1 = nb_step(a_nb_reg, lo, hi);
        nxt  = (nxt1 == moau_pkg::NB_CENTER) ? nb_step(nxt1, lo, hi) : nxt1;

        case (a_mode_reg)
            moau_pkg::MODE_PARENT: begin
                res_x    = a_x_reg >> 1;
                res_y    = a_y_reg >> 1;
                res_z    = a_z_reg >> 1;
                res_last = 1'b1;
            end
            moau_pkg::MODE_CHILDREN: begin
                res_x    = {a_x_reg[COORD_BITS-2:0], a_cnt_reg[2]};
                res_y    = {a_y_reg[COORD_BITS-2:0], a_cnt_reg[1]};
                res_z    = {a_z_reg[COORD_BITS-2:0], a_cnt_reg[0]};
                res_last = &a_cnt_reg;
            end
            moau_pkg::MODE_NEIGHBORS: begin
                res_x    = add_off(a_x_reg, a_nb_reg.dx);
                res_y    = add_off(a_y_reg, a_nb_reg.dy);
                res_z    = add_off(a_z_reg, a_nb_reg.dz);
                res_last = (a_nb_reg == hi) || (nxt1 == moau_pkg::NB_CENTER && nxt1 == hi);
            end
            default: begin
                res_x    = a_x_reg;
                res_y    = a_y_reg;
                res_z    = a_z_reg;
                res_last = 1'b1;
            end
        endcase
    end

    always_comb begin
        a_valid_next = a_valid_reg;
        a_mode_next  = a_mode_reg;
        a_x_next     = a_x_reg;
        a_y_next     = a_y_reg;
        a_z_next     = a_z_reg;
        a_cnt_next   = a_cnt_reg;
        a_nb_next    = a_nb_reg;
        if (a_fire) begin
            a_cnt_next = a_cnt_reg + 3'd1;
            a_nb_next  = nxt;
            if (res_last) begin
                a_valid_next = 1'b0;
            end
        end
        if (a_load) begin
            a_valid_next = 1'b1;
            a_mode_next  = moau_pkg::mode_t'(s_mode);
            a_x_next     = in_x;
            a_y_next     = in_y;
            a_z_next     = in_z;
            a_cnt_next   = '0;
            a_nb_next    = in_start;
        end

        m_valid_next = m_valid_reg && !m_ready;
        m_code_next  = m_code_reg;
        m_x_next     = m_x_reg;
        m_y_next     = m_y_reg;
        m_z_next     = m_z_reg;
        m_last_next  = m_last_reg;
        if (a_fire) begin
            m_valid_next = 1'b1;
            m_code_next  = interleave(res_x, res_y, res_z);
            m_x_next     = res_x;
            m_y_next     = res_y;
            m_z_next     = res_z;
            m_last_next  = res_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_mode_reg <= a_mode_next;
        a_x_reg    <= a_x_next;
        a_y_reg    <= a_y_next;
        a_z_reg    <= a_z_next;
        a_cnt_reg  <= a_cnt_next;
        a_nb_reg   <= a_nb_next;
        m_code_reg <= m_code_next;
        m_x_reg    <= m_x_next;
        m_y_reg    <= m_y_next;
        m_z_reg    <= m_z_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_out_code = m_code_reg;
    assign m_out_x    = moau_pkg::PORT_COORD_W'(m_x_reg);
    assign m_out_y    = moau_pkg::PORT_COORD_W'(m_y_reg);
    assign m_out_z    = moau_pkg::PORT_COORD_W'(m_z_reg);
    assign m_last     = m_last_reg;

endmodule

`default_nettype wire

/* tb/morton_octree_address_unit_test.sv */
// Testbench for morton_octree_address_unit: directed and random words in all five modes,
// checked against a scoreboard that predicts every result word. Depends on moau_pkg and
// the block itself.
`default_nettype none

module morton_octree_address_unit_test;

    localparam int CODE_W       = moau_pkg::CODE_W;
    localparam int PORT_COORD_W = moau_pkg::PORT_COORD_W;
    localparam int MODE_W       = moau_pkg::MODE_W;
    localparam int CB = moau_pkg::COORD_BITS_DEF;
    localparam int LIM = 1 << CB;
    localparam logic [PORT_COORD_W-1:0] AXIS_MAX = PORT_COORD_W'(LIM - 1);
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES = 32;

    typedef struct {
        logic [CODE_W-1:0]       code;
        logic [PORT_COORD_W-1:0] x;
        logic [PORT_COORD_W-1:0] y;
        logic [PORT_COORD_W-1:0] z;
        logic                    last;
    } cell_word_t;

    class cell_scoreboard;
        cell_word_t expected_cells[$];
        int fails;

        function new();
            fails = 0;
        endfunction

        static function logic [CODE_W-1:0] pack_cell(logic [PORT_COORD_W-1:0] x,
                                                     logic [PORT_COORD_W-1:0] y,
                                                     logic [PORT_COORD_W-1:0] z);
            logic [CODE_W-1:0] code;
            code = '0;
            for (int i = 0; i < CB; i++) begin
                code[3*i]     = x[i];
                code[3*i + 1] = y[i];
                code[3*i + 2] = z[i];
            end
            return code;
        endfunction

        static function int unpack_axis(logic [CODE_W-1:0] code, int lane);
            int v;
            v = 0;
            for (int i = 0; i < CB; i++) begin
                v |= int'(code[3*i + lane]) << i;
            end
            return v;
        endfunction

        function void push_cell(int x, int y, int z, logic last);
            cell_word_t c;
            c.x = PORT_COORD_W'(x & (LIM - 1));
            c.y = PORT_COORD_W'(y & (LIM - 1));
            c.z = PORT_COORD_W'(z & (LIM - 1));
            c.code = pack_cell(c.x, c.y, c.z);
            c.last = last;
            expected_cells.push_back(c);
        endfunction

        function void note_word(logic [MODE_W-1:0] mode, logic [CODE_W-1:0] code,
                                logic [PORT_COORD_W-1:0] cx, logic [PORT_COORD_W-1:0] cy,
                                logic [PORT_COORD_W-1:0] cz);
            int px, py, pz, nx, ny, nz;
            px = unpack_axis(code, 0);
            py = unpack_axis(code, 1);
            pz = unpack_axis(code, 2);
            case (moau_pkg::mode_t'(mode))
                moau_pkg::MODE_ENCODE: push_cell(int'(cx), int'(cy), int'(cz), 1'b1);
                moau_pkg::MODE_DECODE: push_cell(px, py, pz, 1'b1);
                moau_pkg::MODE_PARENT: push_cell(px >> 1, py >> 1, pz >> 1, 1'b1);
                moau_pkg::MODE_CHILDREN: begin
                    for (int i = 0; i < 8; i++) begin
                        push_cell((px << 1) + ((i >> 2) & 1), (py << 1) + ((i >> 1) & 1),
                                  (pz << 1) + (i & 1), i == 7);
                    end
                end
                moau_pkg::MODE_NEIGHBORS: begin
                    for (int dz = -1; dz <= 1; dz++) begin
                        for (int dy = -1; dy <= 1; dy++) begin
                            for (int dx = -1; dx <= 1; dx++) begin
                                nx = px + dx;
                                ny = py + dy;
                                nz = pz + dz;
                                if (dx == 0 && dy == 0 && dz == 0) continue;
                                if (nx < 0 || ny < 0 || nz < 0) continue;
                                if (nx >= LIM || ny >= LIM || nz >= LIM) continue;
                                push_cell(nx, ny, nz, 1'b0);
                            end
                        end
                    end
                    expected_cells[expected_cells.size() - 1].last = 1'b1;
                end
                default: ;
            endcase
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            fails++;
        endtask

        task check_word(logic [CODE_W-1:0] code, logic [PORT_COORD_W-1:0] x,
                        logic [PORT_COORD_W-1:0] y, logic [PORT_COORD_W-1:0] z,
                        logic last);
            cell_word_t want;
            if (expected_cells.size() == 0) begin
                report($sformatf("unexpected word code=%h", code));
                return;
            end
            want = expected_cells.pop_front();
            if (code !== want.code)
                report($sformatf("out_code got %h want %h", code, want.code));
            if (x !== want.x) report($sformatf("out_x got %0d want %0d", x, want.x));
            if (y !== want.y) report($sformatf("out_y got %0d want %0d", y, want.y));
            if (z !== want.z) report($sformatf("out_z got %0d want %0d", z, want.z));
            if (last !== want.last)
                report($sformatf("last got %b want %b (code %h)", last, want.last, want.code));
        endtask
    endclass

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [MODE_W-1:0]       s_mode = '0;
    logic [CODE_W-1:0]       s_morton_in = '0;
    logic [PORT_COORD_W-1:0] s_coord_x = '0;
    logic [PORT_COORD_W-1:0] s_coord_y = '0;
    logic [PORT_COORD_W-1:0] s_coord_z = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [CODE_W-1:0]       m_out_code;
    logic [PORT_COORD_W-1:0] m_out_x;
    logic [PORT_COORD_W-1:0] m_out_y;
    logic [PORT_COORD_W-1:0] m_out_z;
    logic                    m_last;

    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    cell_scoreboard sb = new();

    morton_octree_address_unit uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_morton_in(s_morton_in),
        .s_coord_x  (s_coord_x),
        .s_coord_y  (s_coord_y),
        .s_coord_z  (s_coord_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_code (m_out_code),
        .m_out_x    (m_out_x),
        .m_out_y    (m_out_y),
        .m_out_z    (m_out_z),
        .m_last     (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_word(s_mode, s_morton_in, s_coord_x, s_coord_y, s_coord_z);
            if (m_valid && m_ready)
                sb.check_word(m_out_code, m_out_x, m_out_y, m_out_z, m_last);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles == WATCHDOG_LIMIT) begin
                    sb.report("watchdog: no word moved");
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    task automatic send_word(logic [MODE_W-1:0] mode, logic [CODE_W-1:0] code,
                             logic [PORT_COORD_W-1:0] x, logic [PORT_COORD_W-1:0] y,
                             logic [PORT_COORD_W-1:0] z);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_mode      <= mode;
        s_morton_in <= code;
        s_coord_x   <= x;
        s_coord_y   <= y;
        s_coord_z   <= z;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_cells.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [PORT_COORD_W-1:0] pick_axis();
        case ($urandom_range(3))
            0: return PORT_COORD_W'($urandom_range(1));
            1: return AXIS_MAX - PORT_COORD_W'($urandom_range(1));
            default: return PORT_COORD_W'($urandom);
        endcase
    endfunction

    task automatic send_random();
        int pick;
        logic [CODE_W-1:0] code;
        logic [MODE_W-1:0] mode;
        pick = $urandom_range(99);
        code = CODE_W'($urandom);
        if (pick < 18) mode = moau_pkg::MODE_ENCODE;
        else if (pick < 34) mode = moau_pkg::MODE_DECODE;
        else if (pick < 48) mode = moau_pkg::MODE_PARENT;
        else if (pick < 66) mode = moau_pkg::MODE_CHILDREN;
        else if (pick < 94) mode = moau_pkg::MODE_NEIGHBORS;
        else mode = MODE_W'($urandom_range(7, moau_pkg::MODE_NEIGHBORS + 1));
        if ((mode == moau_pkg::MODE_NEIGHBORS || mode == moau_pkg::MODE_CHILDREN)
                && $urandom_range(3) != 0)
            code = cell_scoreboard::pack_cell(pick_axis(), pick_axis(), pick_axis());
        if (mode == moau_pkg::MODE_ENCODE)
            send_word(mode, code, pick_axis(), pick_axis(), pick_axis());
        else
            send_word(mode, code, PORT_COORD_W'($urandom), PORT_COORD_W'($urandom),
                      PORT_COORD_W'($urandom));
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(moau_pkg::MODE_ENCODE, '0, '0, '0, '0);
        send_word(moau_pkg::MODE_ENCODE, '0, AXIS_MAX, AXIS_MAX, AXIS_MAX);
        send_word(moau_pkg::MODE_ENCODE, '1, AXIS_MAX, '0, '0);
        send_word(moau_pkg::MODE_ENCODE, '0, '0, AXIS_MAX, '0);
        send_word(moau_pkg::MODE_ENCODE, '0, '0, '0, AXIS_MAX);
        send_word(moau_pkg::MODE_DECODE, '1, '1, '1, '1);
        send_word(moau_pkg::MODE_DECODE, '0, '0, '0, '0);
        send_word(moau_pkg::MODE_DECODE, 30'h2AAAAAAA, '0, '0, '0);
        send_word(moau_pkg::MODE_PARENT, '1, '0, '0, '0);
        send_word(moau_pkg::MODE_PARENT, cell_scoreboard::pack_cell(1, 0, 1),
                  '0, '0, '0);
        send_word(moau_pkg::MODE_CHILDREN, '0, '0, '0, '0);
        send_word(moau_pkg::MODE_CHILDREN, '1, '0, '0, '0);
        send_word(moau_pkg::MODE_CHILDREN, cell_scoreboard::pack_cell(511, 512, 0),
                  '0, '0, '0);
        send_word(moau_pkg::MODE_NEIGHBORS, '0, '0, '0, '0);
        send_word(moau_pkg::MODE_NEIGHBORS, '1, '0, '0, '0);
        send_word(moau_pkg::MODE_NEIGHBORS, cell_scoreboard::pack_cell(0, 500, AXIS_MAX),
                  '0, '0, '0);
        send_word(moau_pkg::MODE_NEIGHBORS, cell_scoreboard::pack_cell(5, 6, 7),
                  '0, '0, '0);
        send_word(moau_pkg::MODE_NEIGHBORS, cell_scoreboard::pack_cell(1022, 1, 512),
                  '0, '0, '0);
        for (int m = moau_pkg::MODE_NEIGHBORS + 1; m < (1 << MODE_W); m++)
            send_word(MODE_W'(m), '1, '1, '1, '1);
        hold_until_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            repeat (65) send_random();
            hold_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (sb.fails == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
